// ----- design/pts_pkg.sv -----
// Package for the priority task scheduler: widths, command codes, task state codes.
// No dependencies.
package pts_pkg;
  localparam int TASKS_DEF = 8;
  localparam int ALARMS_DEF = 4;
  localparam int MAILBOXES_DEF = 4;
  localparam int PRIORITY_BITS_DEF = 4;
  localparam int COUNT_BITS_DEF = 16;
  localparam int IDX_BITS = 3;
  localparam int MBX_IDX_BITS = 2;
  localparam int FUNC_BITS = 3;
  localparam int WORD_BITS = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_TICK = 3'd1;
  localparam logic [2:0] FN_ACTIVATE = 3'd2;
  localparam logic [2:0] FN_CHAIN = 3'd3;
  localparam logic [2:0] FN_TERMINATE = 3'd4;
  localparam logic [2:0] FN_WAIT = 3'd5;
  localparam logic [2:0] FN_MB_WRITE = 3'd6;
  localparam logic [2:0] FN_MB_READ = 3'd7;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_OWNER = 2'd1;
  localparam logic [1:0] STS_FULL_EMPTY = 2'd2;

  localparam logic [2:0] REG_PRIO = 3'd0;
  localparam logic [2:0] REG_AUTOSTART = 3'd1;
  localparam logic [2:0] REG_RELOADS = 3'd2;
  localparam logic [2:0] REG_ALARM_TASKS = 3'd3;
  localparam logic [2:0] REG_RECURRENT = 3'd4;
  localparam logic [2:0] REG_ENABLE = 3'd5;
  localparam logic [2:0] REG_PRODUCERS = 3'd6;
  localparam logic [2:0] REG_CONSUMERS = 3'd7;
endpackage

// ----- design/pts_if.sv -----
// Valid/ready channel interfaces for commands and results.
// Depends on pts_pkg.
interface pts_cmd_if;
  logic valid;
  logic ready;
  logic [pts_pkg::FUNC_BITS-1:0] func;
  logic [pts_pkg::IDX_BITS-1:0] task_index;
  logic [pts_pkg::MBX_IDX_BITS-1:0] mailbox_index;
  logic [pts_pkg::WORD_BITS-1:0] write_data;
  modport source (output valid, func, task_index, mailbox_index, write_data, input ready);
  modport sink (input valid, func, task_index, mailbox_index, write_data, output ready);
endinterface

interface pts_res_if;
  logic valid;
  logic ready;
  logic task_valid;
  logic [pts_pkg::IDX_BITS-1:0] running_task;
  logic resume_interrupted;
  logic [1:0] status;
  logic [pts_pkg::WORD_BITS-1:0] read_data;
  modport source (output valid, task_valid, running_task, resume_interrupted, status,
    read_data, input ready);
  modport sink (input valid, task_valid, running_task, resume_interrupted, status,
    read_data, output ready);
endinterface

// ----- design/pts_select.sv -----
// Selection unit: one task per cycle is woken from its mailboxes and compared
// against the best ready task so far. Depends on pts_pkg.
module pts_select #(
  parameter int TASKS = pts_pkg::TASKS_DEF,
  parameter int MAILBOXES = pts_pkg::MAILBOXES_DEF,
  parameter int PRIORITY_BITS = pts_pkg::PRIORITY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [$clog2(TASKS)-1:0] idx,
  input  logic [1:0] state_in,
  input  logic [TASKS*PRIORITY_BITS-1:0] prios,
  input  logic [MAILBOXES*pts_pkg::IDX_BITS-1:0] producers,
  input  logic [MAILBOXES*pts_pkg::IDX_BITS-1:0] consumers,
  input  logic [MAILBOXES-1:0] mb_full,
  output logic [1:0] state_out,
  output logic found,
  output logic [$clog2(TASKS)-1:0] best
);
  localparam int TW = $clog2(TASKS);
  logic [PRIORITY_BITS-1:0] bestp;
  logic [PRIORITY_BITS-1:0] pr;
  logic [1:0] st;

  always_comb begin
    st = state_in;
    if (state_in == pts_pkg::ST_WAIT) begin
      for (int m = 0; m < MAILBOXES; m++) begin
        if (producers[m*pts_pkg::IDX_BITS +: pts_pkg::IDX_BITS] ==
            pts_pkg::IDX_BITS'(idx)) begin
          if (!mb_full[m]) st = pts_pkg::ST_READY;
        end else if (consumers[m*pts_pkg::IDX_BITS +: pts_pkg::IDX_BITS] ==
            pts_pkg::IDX_BITS'(idx)) begin
          if (mb_full[m]) st = pts_pkg::ST_READY;
        end
      end
    end
    pr = prios[idx*PRIORITY_BITS +: PRIORITY_BITS];
  end

  assign state_out = st;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= 1'b0;
      best <= '0;
      bestp <= '0;
    end else if (st == pts_pkg::ST_READY && (!found || pr >= bestp)) begin
      found <= 1'b1;
      best <= TW'(idx);
      bestp <= pr;
    end
  end
endmodule

// ----- design/priority_task_scheduler_with_alarms_core.sv -----
// Top level of the priority task scheduler: configuration registers, task and
// alarm state, sequencer, result register. Depends on pts_pkg, pts_if, pts_select.
//
// Commands arrive on cmd (valid/ready); each produces one result on res.
// A command is taken only while the block is idle. Mailbox commands go from
// idle straight to the output step, which registers the result. Other commands
// update state, sweep the alarms one per cycle (ticks only), then sweep the
// tasks one per cycle through the shared selection unit, then commit.
// The result sits in an output register until its transfer; the next command
// is taken only after that transfer, so a stalled receiver holds the block.
// User writes configuration via cfg_we/cfg_index/cfg_data only while idle (not enforced).
// Reset (synchronous, active high) makes all tasks idle, clears running,
// interrupted flags, alarms, mailboxes and registers; no clearing pass.
module priority_task_scheduler_with_alarms_core #(
  parameter int TASKS = pts_pkg::TASKS_DEF,
  parameter int ALARMS = pts_pkg::ALARMS_DEF,
  parameter int MAILBOXES = pts_pkg::MAILBOXES_DEF,
  parameter int PRIORITY_BITS = pts_pkg::PRIORITY_BITS_DEF,
  parameter int COUNT_BITS = pts_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pts_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pts_pkg::CFG_DATA_BITS-1:0] cfg_data,
  pts_cmd_if.sink cmd,
  pts_res_if.source res
);
  localparam int TW = $clog2(TASKS);
  localparam int AW = (ALARMS > 1) ? $clog2(ALARMS) : 1;
  localparam int MW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam int IB = pts_pkg::IDX_BITS;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALARM = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [TASKS*PRIORITY_BITS-1:0] prios;
  logic [TASKS-1:0] autostart;
  logic [ALARMS*COUNT_BITS-1:0] reloads;
  logic [ALARMS*IB-1:0] alarm_tasks;
  logic [ALARMS-1:0] recurrent;
  logic [ALARMS-1:0] enable;
  logic [MAILBOXES*IB-1:0] producers;
  logic [MAILBOXES*IB-1:0] consumers;

  logic [1:0] task_state [TASKS];
  logic [TASKS-1:0] interrupted;
  logic run_valid;
  logic [TW-1:0] running_id;
  logic [COUNT_BITS-1:0] alarm_count [ALARMS];
  logic [ALARMS-1:0] armed;
  logic [MAILBOXES-1:0] mb_full;
  logic [pts_pkg::WORD_BITS-1:0] mb_word [MAILBOXES];

  logic [2:0] state;
  logic [TW-1:0] tcnt;
  logic [AW-1:0] acnt;
  logic [2:0] func;
  logic [pts_pkg::MBX_IDX_BITS-1:0] midx;
  logic [pts_pkg::WORD_BITS-1:0] wdata;

  logic [1:0] sel_state;
  logic sel_found;
  logic [TW-1:0] sel_best;
  logic [COUNT_BITS-1:0] dec;
  logic [IB-1:0] atask;
  logic take;
  logic mb_ok_idx;
  logic [MW-1:0] mi;

  assign take = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE) && !res.valid;
  assign mb_ok_idx = 32'(midx) < MAILBOXES;
  assign mi = MW'(midx);
  assign dec = alarm_count[acnt] - COUNT_BITS'(1);
  assign atask = alarm_tasks[acnt*IB +: IB];

  pts_select #(.TASKS(TASKS), .MAILBOXES(MAILBOXES), .PRIORITY_BITS(PRIORITY_BITS)) u_sel (
    .clk(clk), .rst(rst), .start(state == S_IDLE), .idx(tcnt),
    .state_in(task_state[tcnt]), .prios(prios), .producers(producers),
    .consumers(consumers), .mb_full(mb_full), .state_out(sel_state),
    .found(sel_found), .best(sel_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prios <= '0;
      autostart <= '0;
      reloads <= '0;
      alarm_tasks <= '0;
      recurrent <= '0;
      enable <= '0;
      producers <= '0;
      consumers <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pts_pkg::REG_PRIO: prios <= (TASKS*PRIORITY_BITS)'(cfg_data);
        pts_pkg::REG_AUTOSTART: autostart <= TASKS'(cfg_data);
        pts_pkg::REG_RELOADS: reloads <= (ALARMS*COUNT_BITS)'(cfg_data);
        pts_pkg::REG_ALARM_TASKS: alarm_tasks <= (ALARMS*IB)'(cfg_data);
        pts_pkg::REG_RECURRENT: recurrent <= ALARMS'(cfg_data);
        pts_pkg::REG_ENABLE: enable <= ALARMS'(cfg_data);
        pts_pkg::REG_PRODUCERS: producers <= (MAILBOXES*IB)'(cfg_data);
        pts_pkg::REG_CONSUMERS: consumers <= (MAILBOXES*IB)'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < TASKS; k++) task_state[k] <= pts_pkg::ST_IDLE;
      for (int k = 0; k < ALARMS; k++) alarm_count[k] <= '0;
      for (int k = 0; k < MAILBOXES; k++) mb_word[k] <= '0;
      interrupted <= '0;
      run_valid <= 1'b0;
      running_id <= '0;
      armed <= '0;
      mb_full <= '0;
      tcnt <= '0;
      acnt <= '0;
      res.valid <= 1'b0;
      res.task_valid <= 1'b0;
      res.running_task <= '0;
      res.resume_interrupted <= 1'b0;
      res.status <= pts_pkg::STS_OK;
      res.read_data <= '0;
      func <= '0;
      midx <= '0;
      wdata <= '0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          tcnt <= '0;
          acnt <= '0;
          if (take) begin
            func <= cmd.func;
            midx <= cmd.mailbox_index;
            wdata <= cmd.write_data;
            if (cmd.func == pts_pkg::FN_MB_WRITE || cmd.func == pts_pkg::FN_MB_READ) begin
              state <= S_OUT;
            end else begin
              state <= (cmd.func == pts_pkg::FN_TICK) ? S_ALARM : S_SCAN;
              unique case (cmd.func)
                pts_pkg::FN_START: begin
                  if (run_valid) task_state[running_id] <= pts_pkg::ST_READY;
                  for (int k = 0; k < TASKS; k++)
                    if (autostart[k]) task_state[k] <= pts_pkg::ST_READY;
                  for (int k = 0; k < ALARMS; k++)
                    alarm_count[k] <= reloads[k*COUNT_BITS +: COUNT_BITS];
                  armed <= enable;
                end
                pts_pkg::FN_TICK: begin
                  if (run_valid) begin
                    interrupted[running_id] <= 1'b1;
                    task_state[running_id] <= pts_pkg::ST_READY;
                  end
                end
                pts_pkg::FN_ACTIVATE: begin
                  if (run_valid) task_state[running_id] <= pts_pkg::ST_READY;
                  if (32'(cmd.task_index) < TASKS) begin
                    if (task_state[TW'(cmd.task_index)] == pts_pkg::ST_IDLE ||
                        (run_valid && running_id == TW'(cmd.task_index)))
                      task_state[TW'(cmd.task_index)] <= pts_pkg::ST_READY;
                  end
                end
                pts_pkg::FN_CHAIN: begin
                  if (run_valid) task_state[running_id] <= pts_pkg::ST_IDLE;
                  if (32'(cmd.task_index) < TASKS)
                    task_state[TW'(cmd.task_index)] <= pts_pkg::ST_READY;
                end
                pts_pkg::FN_TERMINATE: begin
                  if (run_valid) task_state[running_id] <= pts_pkg::ST_IDLE;
                end
                default: begin
                  if (run_valid) task_state[running_id] <= pts_pkg::ST_WAIT;
                end
              endcase
            end
          end
        end
        S_ALARM: begin
          if (armed[acnt]) begin
            if (dec == '0) begin
              if (32'(atask) < TASKS) task_state[TW'(atask)] <= pts_pkg::ST_READY;
              if (recurrent[acnt]) alarm_count[acnt] <= reloads[acnt*COUNT_BITS +: COUNT_BITS];
              else begin
                alarm_count[acnt] <= dec;
                armed[acnt] <= 1'b0;
              end
            end else begin
              alarm_count[acnt] <= dec;
            end
          end
          acnt <= acnt + AW'(1);
          if (32'(acnt) == ALARMS - 1) state <= S_SCAN;
        end
        S_SCAN: begin
          task_state[tcnt] <= sel_state;
          tcnt <= tcnt + TW'(1);
          if (32'(tcnt) == TASKS - 1) state <= S_COMMIT;
        end
        S_COMMIT: begin
          run_valid <= sel_found;
          running_id <= sel_found ? sel_best : '0;
          res.valid <= 1'b1;
          res.task_valid <= sel_found;
          res.running_task <= sel_found ? IB'(sel_best) : '0;
          res.resume_interrupted <= sel_found && interrupted[sel_best];
          res.status <= pts_pkg::STS_OK;
          res.read_data <= '0;
          if (sel_found) begin
            task_state[sel_best] <= pts_pkg::ST_RUN;
            interrupted[sel_best] <= 1'b0;
          end
          state <= S_IDLE;
        end
        S_OUT: begin
          res.valid <= 1'b1;
          res.task_valid <= run_valid;
          res.running_task <= IB'(running_id);
          res.resume_interrupted <= 1'b0;
          if (!run_valid || !mb_ok_idx) begin
            res.status <= pts_pkg::STS_OWNER;
            res.read_data <= '0;
          end else if (func == pts_pkg::FN_MB_WRITE) begin
            res.read_data <= '0;
            if (producers[mi*IB +: IB] != IB'(running_id)) res.status <= pts_pkg::STS_OWNER;
            else if (mb_full[mi]) res.status <= pts_pkg::STS_FULL_EMPTY;
            else begin
              res.status <= pts_pkg::STS_OK;
              mb_word[mi] <= wdata;
              mb_full[mi] <= 1'b1;
            end
          end else begin
            if (consumers[mi*IB +: IB] != IB'(running_id)) begin
              res.status <= pts_pkg::STS_OWNER;
              res.read_data <= '0;
            end else if (!mb_full[mi]) begin
              res.status <= pts_pkg::STS_FULL_EMPTY;
              res.read_data <= '0;
            end else begin
              res.status <= pts_pkg::STS_OK;
              res.read_data <= mb_word[mi];
              mb_full[mi] <= 1'b0;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !res.valid) else $error("ready while a result is pending");
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |=> res.valid) else $error("commit without result");
  a_result_zero_task: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.task_valid |-> res.running_task == '0)
    else $error("running task not zero with no task");
  a_run_state: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && run_valid |-> task_state[running_id] == pts_pkg::ST_RUN)
    else $error("running task not in run state");
endmodule
